// ----- src/ftwa_pkg.sv -----
// Shared types and constants of the frame time window averager.
// Used by the serial divider lane and the top level; depends on nothing.
`timescale 1ns / 1ps
`default_nettype none

package ftwa_pkg;

  localparam int DATA_W      = 24;
  localparam int SUM_W       = 48;
  localparam int ELAPSED_W   = 25;
  localparam int COUNT_W     = 20;
  localparam int QUANT_N     = 4;
  localparam int DIV_STEPS   = DATA_W;
  localparam int IN_TDATA_W  = QUANT_N * DATA_W;
  localparam int OUT_FIELD_W = 2 * QUANT_N * DATA_W + 4;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;
  localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_FIELD_W;

  localparam logic [DATA_W-1:0] WINDOW_RESET = DATA_W'(1000000);
  localparam logic [DATA_W-1:0] DATA_MAX     = '1;

  // Four quantities side by side: frame, physics, render, present.
  typedef logic [QUANT_N-1:0][DATA_W-1:0] quad_t;

  typedef struct packed {
    logic               start;
    logic [SUM_W-1:0]   dividend;
    logic [COUNT_W-1:0] divisor;
  } div_req_t;

endpackage

`default_nettype wire

// ----- src/ftwa_ram.sv -----
// Generic single-write, single-read RAM with a registered read port.
// Holds the history ring; no dependencies.
`timescale 1ns / 1ps
`default_nettype none

module ftwa_ram #(
  parameter int WIDTH = 96,
  parameter int DEPTH = 10
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

`default_nettype wire

// ----- src/ftwa_div.sv -----
// Bit-serial restoring divider lane: one quotient bit per cycle, 24-bit
// quotient with saturation. Depends on ftwa_pkg.
`timescale 1ns / 1ps
`default_nettype none

module ftwa_div (
  input  logic                         clk,
  input  logic                         rst_n,
  input  ftwa_pkg::div_req_t           req,
  output logic                         done,
  output logic [ftwa_pkg::DATA_W-1:0]  quot
);

  import ftwa_pkg::*;

  localparam int CNT_W = $clog2(DIV_STEPS);

  logic               busy_r, busy_nxt;
  logic               done_r, done_nxt;
  logic [CNT_W-1:0]   cnt_r, cnt_nxt;
  logic               sat_r, sat_nxt;
  logic [COUNT_W-1:0] rem_r, rem_nxt;
  logic [COUNT_W-1:0] div_r, div_nxt;
  logic [DATA_W-1:0]  q_r, q_nxt;

  logic [COUNT_W:0]   shifted;
  logic [COUNT_W+1:0] diff;
  logic               borrow;

  always_comb begin
    shifted  = {rem_r, q_r[DATA_W-1]};
    diff     = {1'b0, shifted} - {2'b00, div_r};
    borrow   = diff[COUNT_W+1];

    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    sat_nxt  = sat_r;
    rem_nxt  = rem_r;
    div_nxt  = div_r;
    q_nxt    = q_r;

    if (req.start) begin
      // The quotient fits 24 bits exactly when the upper half of the
      // dividend is below the divisor; that upper half is then the start
      // remainder.
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
      sat_nxt  = req.dividend[SUM_W-1:DATA_W] >= (SUM_W - DATA_W)'(req.divisor);
      rem_nxt  = req.dividend[DATA_W+COUNT_W-1:DATA_W];
      div_nxt  = req.divisor;
      q_nxt    = req.dividend[DATA_W-1:0];
    end else if (busy_r) begin
      rem_nxt = borrow ? shifted[COUNT_W-1:0] : diff[COUNT_W-1:0];
      q_nxt   = {q_r[DATA_W-2:0], ~borrow};
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNT_W'(DIV_STEPS - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    sat_r <= sat_nxt;
    rem_r <= rem_nxt;
    div_r <= div_nxt;
    q_r   <= q_nxt;
  end

  assign done = done_r;
  assign quot = sat_r ? DATA_MAX : q_r;

endmodule

`default_nettype wire

// ----- src/frame_time_window_averager_unit.sv -----
// Top level of the frame time window averager: accumulators, window
// control, history ring and four divider lanes. Depends on ftwa_pkg,
// ftwa_div and ftwa_ram.
//
// Usage. One input beat on in_* carries four 24-bit durations in
// microseconds (frame, physics, render, present). Every input beat yields
// exactly one output beat on out_*, in order. out_tuser flags that this
// beat closed a window; out_tdata carries the latest window means, the
// history fill and the means over the history ring.
// The user must write the window length on the cfg_* channel only while the
// block is idle; the block itself does not enforce this. cfg_ready is always high.
// Timing. A beat that does not close a window passes from the input register
// through S_ACC and S_OUT into the output register. A closing beat runs two
// 24-step bit-serial divisions back to back on the four divider lanes (window
// means, then history means) in S_WDIV, S_HSTART and S_HDIV, before S_OUT
// loads the output register. One beat is worked on at a time: in_tready is
// high only while the block waits.
// Reset (rst_n, synchronous) clears sums, means, the ring fill and the
// window length to 1000000 us. The ring memory is not cleared; only filled
// slots are ever summed.
// Stalls. The output register holds its beat while out_tready is low. The
// next beat is still accepted and processed, then waits for the register.
`timescale 1ns / 1ps
`default_nettype none

module frame_time_window_averager_unit #(
  parameter int HISTORY_DEPTH = 10
) (
  input  logic                               clk,
  input  logic                               rst_n,
  // in_tdata, low bit up: frame_time, physics_time, render_time,
  // present_time (24 bits each)
  input  logic                               in_tvalid,
  output logic                               in_tready,
  input  logic [ftwa_pkg::IN_TDATA_W-1:0]    in_tdata,
  // out_tdata, low bit up: window_frame_mean, window_physics_mean,
  // window_render_mean, window_present_mean (24 each), history_fill (4),
  // history_frame_mean, history_physics_mean, history_render_mean,
  // history_present_mean (24 each), zero padding
  output logic                               out_tvalid,
  input  logic                               out_tready,
  output logic [ftwa_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // out_tuser: window_closed
  output logic                               out_tuser,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [ftwa_pkg::DATA_W-1:0]        cfg_data
);

  import ftwa_pkg::*;

  localparam int FILL_W = $clog2(HISTORY_DEPTH + 1);
  localparam int TOT_W  = DATA_W + FILL_W;
  localparam int AW     = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;

  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_ACC    = 6'b000010,
    S_WDIV   = 6'b000100,
    S_HSTART = 6'b001000,
    S_HDIV   = 6'b010000,
    S_OUT    = 6'b100000
  } state_t;

  state_t                          state_r, state_nxt;
  logic [DATA_W-1:0]               win_len_r, win_len_nxt;
  quad_t                           in_r, in_nxt;
  logic [QUANT_N-1:0][SUM_W-1:0]   sum_r, sum_nxt;
  logic [ELAPSED_W-1:0]            elapsed_r, elapsed_nxt;
  logic [COUNT_W-1:0]              count_r, count_nxt;
  quad_t                           latest_r, latest_nxt;
  quad_t                           hist_mean_r, hist_mean_nxt;
  logic [QUANT_N-1:0][TOT_W-1:0]   tot_r, tot_nxt;
  logic [AW-1:0]                   slot_r, slot_nxt;
  logic [FILL_W-1:0]               fill_r, fill_nxt;
  logic                            closed_r, closed_nxt;
  logic                            out_valid_r, out_valid_nxt;
  logic [OUT_TDATA_W-1:0]          out_data_r, out_data_nxt;
  logic                            out_user_r, out_user_nxt;

  logic [QUANT_N-1:0][SUM_W-1:0]   sum_add;
  logic [SUM_W:0]                  sum_wide [QUANT_N];
  logic [ELAPSED_W:0]              elapsed_wide;
  logic [ELAPSED_W-1:0]            elapsed_add;
  logic [COUNT_W-1:0]              count_add;
  logic                            close;
  logic                            full;

  div_req_t    [QUANT_N-1:0]       div_req;
  logic        [QUANT_N-1:0]       div_done;
  quad_t                           div_quot;
  quad_t                           ring_old;
  logic                            ram_we;

  // Saturating accumulation of the held beat, and the window-close and ring-full tests.
  always_comb begin
    for (int k = 0; k < QUANT_N; k++) begin
      sum_wide[k] = {1'b0, sum_r[k]} + (SUM_W + 1)'(in_r[k]);
      sum_add[k]  = sum_wide[k][SUM_W] ? {SUM_W{1'b1}} : sum_wide[k][SUM_W-1:0];
    end
    elapsed_wide = {1'b0, elapsed_r} + (ELAPSED_W + 1)'(in_r[0]);
    elapsed_add  = elapsed_wide[ELAPSED_W] ? {ELAPSED_W{1'b1}}
                                           : elapsed_wide[ELAPSED_W-1:0];
    count_add    = (count_r == {COUNT_W{1'b1}}) ? count_r : count_r + 1'b1;
    close        = elapsed_add >= ELAPSED_W'(win_len_r);
    full         = fill_r == FILL_W'(HISTORY_DEPTH);
  end

  // The lanes divide the fresh window sums by the sample count first, then
  // the history totals by the ring fill.
  always_comb begin
    for (int k = 0; k < QUANT_N; k++) begin
      div_req[k].start    = (state_r == S_ACC && close) || state_r == S_HSTART;
      div_req[k].dividend = (state_r == S_HSTART) ? SUM_W'(tot_r[k]) : sum_add[k];
      div_req[k].divisor  = (state_r == S_HSTART) ? COUNT_W'(fill_r) : count_add;
    end
  end

  for (genvar g = 0; g < QUANT_N; g++) begin : g_lane
    ftwa_div u_div (
      .clk  (clk),
      .rst_n(rst_n),
      .req  (div_req[g]),
      .done (div_done[g]),
      .quot (div_quot[g])
    );
  end

  // The read port always looks at the next write slot, so the entry about
  // to be overwritten is ready when the window means arrive.
  assign ram_we = (state_r == S_WDIV) && div_done[0];

  ftwa_ram #(
    .WIDTH(IN_TDATA_W),
    .DEPTH(HISTORY_DEPTH)
  ) u_ring (
    .clk  (clk),
    .we   (ram_we),
    .waddr(slot_r),
    .wdata(div_quot),
    .raddr(slot_r),
    .rdata(ring_old)
  );

  always_comb begin
    state_nxt     = state_r;
    win_len_nxt   = win_len_r;
    in_nxt        = in_r;
    sum_nxt       = sum_r;
    elapsed_nxt   = elapsed_r;
    count_nxt     = count_r;
    latest_nxt    = latest_r;
    hist_mean_nxt = hist_mean_r;
    tot_nxt       = tot_r;
    slot_nxt      = slot_r;
    fill_nxt      = fill_r;
    closed_nxt    = closed_r;
    out_valid_nxt = out_valid_r;
    out_data_nxt  = out_data_r;
    out_user_nxt  = out_user_r;

    if (cfg_valid) begin
      win_len_nxt = cfg_data;
    end

    if (out_valid_r && out_tready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          in_nxt    = in_tdata;
          state_nxt = S_ACC;
        end
      end
      S_ACC: begin
        closed_nxt = close;
        if (close) begin
          sum_nxt     = '0;
          elapsed_nxt = '0;
          count_nxt   = '0;
          state_nxt   = S_WDIV;
        end else begin
          sum_nxt     = sum_add;
          elapsed_nxt = elapsed_add;
          count_nxt   = count_add;
          state_nxt   = S_OUT;
        end
      end
      S_WDIV: begin
        if (div_done[0]) begin
          latest_nxt = div_quot;
          // Running totals of the ring: add the new mean, drop the one it
          // replaces once the ring has wrapped.
          for (int k = 0; k < QUANT_N; k++) begin
            tot_nxt[k] = tot_r[k] + TOT_W'(div_quot[k])
                         - (full ? TOT_W'(ring_old[k]) : {TOT_W{1'b0}});
          end
          slot_nxt  = (slot_r == AW'(HISTORY_DEPTH - 1)) ? '0 : slot_r + 1'b1;
          fill_nxt  = full ? fill_r : fill_r + 1'b1;
          state_nxt = S_HSTART;
        end
      end
      S_HSTART: begin
        state_nxt = S_HDIV;
      end
      S_HDIV: begin
        if (div_done[0]) begin
          hist_mean_nxt = div_quot;
          state_nxt     = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_valid_nxt = 1'b1;
          out_user_nxt  = closed_r;
          out_data_nxt  = {{OUT_PAD_W{1'b0}}, hist_mean_r, 4'(fill_r), latest_r};
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      win_len_r   <= WINDOW_RESET;
      sum_r       <= '0;
      elapsed_r   <= '0;
      count_r     <= '0;
      latest_r    <= '0;
      hist_mean_r <= '0;
      tot_r       <= '0;
      slot_r      <= '0;
      fill_r      <= '0;
      closed_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      win_len_r   <= win_len_nxt;
      sum_r       <= sum_nxt;
      elapsed_r   <= elapsed_nxt;
      count_r     <= count_nxt;
      latest_r    <= latest_nxt;
      hist_mean_r <= hist_mean_nxt;
      tot_r       <= tot_nxt;
      slot_r      <= slot_nxt;
      fill_r      <= fill_nxt;
      closed_r    <= closed_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    in_r       <= in_nxt;
    out_data_r <= out_data_nxt;
    out_user_r <= out_user_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_user_r;

`ifndef SYNTHESIS
  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= FILL_W'(HISTORY_DEPTH))
    else $error("history fill exceeds ring depth");

  a_slot_tracks_fill: assert property (@(posedge clk) disable iff (!rst_n)
    (fill_r != FILL_W'(HISTORY_DEPTH)) |-> (FILL_W'(slot_r) == fill_r))
    else $error("write slot out of step with fill before the ring wraps");

  a_lanes_lockstep: assert property (@(posedge clk) disable iff (!rst_n)
    (div_done == '0) || (div_done == '1))
    else $error("divider lanes finished in different cycles");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r == S_ACC))
    else $error("accepted beat did not enter accumulation");

  a_out_from_out_state: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> $past(state_r == S_OUT))
    else $error("output beat raised outside the output state");
`endif

endmodule

`default_nettype wire
